// File: rtl/core/balance_robot_pitch_controller_core_assert.svh
// ----------------------------------------------------------------------------
// Pitch controller assertion macros
// Shared concurrent assertion forms, clocked on clk, off during reset.
// ----------------------------------------------------------------------------
`ifndef BALANCE_ROBOT_PITCH_CONTROLLER_CORE_ASSERT_SVH
`define BALANCE_ROBOT_PITCH_CONTROLLER_CORE_ASSERT_SVH

// implication checked at every edge outside reset
`define BRPC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// condition that must never be seen outside reset
`define BRPC_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

// File: rtl/core/brpc_pkg.sv
// ----------------------------------------------------------------------------
// Pitch controller package
// Sequencer codes, register indexes, CORDIC angle table and saturation.
// ----------------------------------------------------------------------------
package brpc_pkg;

	typedef enum logic [3:0] {
		ST_IDLE, ST_PRE, ST_CORDIC, ST_ATAN, ST_MUL, ST_ACC, ST_FIN1, ST_FIN2
	} state_t;

	typedef enum logic [2:0] {
		MS_INCR, MS_GYRO, MS_ACCEL, MS_RATE, MS_GA, MS_GR, MS_GW
	} mstep_t;

	localparam logic [2:0] REG_ALPHA      = 3'd0;
	localparam logic [2:0] REG_TIME_STEP  = 3'd1;
	localparam logic [2:0] REG_INV_STEP   = 3'd2;
	localparam logic [2:0] REG_GAIN_ANGLE = 3'd3;
	localparam logic [2:0] REG_GAIN_RATE  = 3'd4;
	localparam logic [2:0] REG_GAIN_WHEEL = 3'd5;
	localparam logic [2:0] REG_TORQUE_LIM = 3'd6;
	localparam logic [2:0] REG_INIT_PITCH = 3'd7;

	localparam int ATAN_LEN   = 24;
	localparam int ATAN_IDX_W = 5;

	// atan(2^-i) in Q2.30
	localparam logic [31:0] ATAN_TAB [0:ATAN_LEN-1] = '{
		32'd843314857, 32'd497837829, 32'd263043837, 32'd133525159,
		32'd67021687,  32'd33543516,  32'd16775851,  32'd8388437,
		32'd4194283,   32'd2097149,   32'd1048576,   32'd524288,
		32'd262144,    32'd131072,    32'd65536,     32'd32768,
		32'd16384,     32'd8192,      32'd4096,      32'd2048,
		32'd1024,      32'd512,       32'd256,       32'd128
	};

	localparam logic signed [34:0] PI_Q30 = 35'sd3373259426;

	function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
		logic signed [31:0] r;
		if (v > 68'sd2147483647)
			r = 32'sh7FFFFFFF;
		else if (v < -68'sd2147483648)
			r = 32'sh80000000;
		else
			r = v[31:0];
		return r;
	endfunction

endpackage

// File: rtl/core/balance_robot_pitch_controller_core.sv
// ----------------------------------------------------------------------------
// Balance robot pitch controller
// Complementary-filter pitch estimate and state-feedback wheel torques.
// ----------------------------------------------------------------------------
// One item is one control tick. The two warm-up ticks after reset give zero
// torque. Every later tick runs the vectoring CORDIC, one iteration a cycle,
// and seven products through the one shared 34x34 multiplier, each issued in
// ST_MUL and accumulated in ST_ACC. in_ready is high only while the sequencer
// is idle; a finished result waits in the output register while the next
// item is taken.
module balance_robot_pitch_controller_core
	import brpc_pkg::*;
#(
	parameter int CORDIC_STEPS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [15:0] accel_forward,
	input  logic signed [15:0] accel_vertical,
	input  logic signed [31:0] pitch_rate,
	input  logic signed [31:0] yaw_rate,
	input  logic signed [31:0] wheel_rate_left,
	input  logic signed [31:0] wheel_rate_right,
	input  logic signed [31:0] forward_speed_ref,
	input  logic signed [31:0] yaw_rate_ref,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] torque_left,
	output logic signed [31:0] torque_right
);

	localparam int CNT_W = $clog2(CORDIC_STEPS);

	// configuration
	logic [15:0]        alpha_q;
	logic [23:0]        tstep_q;
	logic [15:0]        inv_q;
	logic signed [31:0] g_ang_q, g_rate_q, g_wheel_q, init_q;
	logic [30:0]        lim_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q   <= 16'd65463;
			tstep_q   <= 24'd16777;
			inv_q     <= 16'd1000;
			g_ang_q   <= -32'sd73363000;
			g_rate_q  <= -32'sd26059400;
			g_wheel_q <= -32'sd926810;
			lim_q     <= 31'd32768000;
			init_q    <= 32'sd0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ALPHA:      alpha_q   <= cfg_data[15:0];
				REG_TIME_STEP:  tstep_q   <= cfg_data[23:0];
				REG_INV_STEP:   inv_q     <= cfg_data[15:0];
				REG_GAIN_ANGLE: g_ang_q   <= cfg_data;
				REG_GAIN_RATE:  g_rate_q  <= cfg_data;
				REG_GAIN_WHEEL: g_wheel_q <= cfg_data;
				REG_TORQUE_LIM: lim_q     <= cfg_data[30:0];
				REG_INIT_PITCH: init_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	state_t state_q, state_d;
	mstep_t mstep_q;
	logic [CNT_W-1:0] cnt_q;
	logic [1:0]       warmup_q;
	logic             warm_q, out_valid_q;
	logic signed [31:0] fp_q, prev_q;

	logic signed [15:0] ax_q, az_q;
	logic signed [31:0] wy_q, wz_q, wl_q, wr_q, vref_q, wzref_q;
	logic signed [33:0] cx_q, cy_q;
	logic signed [34:0] cz_q;
	logic               zero_q;
	logic signed [31:0] acc_q, theta_q, dtheta_q, dphi_q, u_q;
	logic signed [33:0] fsum_q;
	logic signed [51:0] sum_q;
	logic signed [49:0] uacc_q;
	logic signed [35:0] diff_q;
	logic signed [67:0] prod_q;
	logic signed [31:0] tl_q, tr_q;

	logic accept, out_free, cordic_last, warm_take;

	assign accept      = in_valid && in_ready;
	assign out_free    = !out_valid_q || out_ready;
	assign cordic_last = (cnt_q == CNT_W'(CORDIC_STEPS - 1));
	assign warm_take   = (warmup_q != 2'd2);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:   if (in_valid) state_d = warm_take ? ST_FIN2 : ST_PRE;
			ST_PRE:    state_d = ST_CORDIC;
			ST_CORDIC: if (cordic_last) state_d = ST_ATAN;
			ST_ATAN:   state_d = ST_MUL;
			ST_MUL:    state_d = ST_ACC;
			ST_ACC:    state_d = (mstep_q == MS_GW) ? ST_FIN1 : ST_MUL;
			ST_FIN1:   state_d = ST_FIN2;
			ST_FIN2:   if (out_free) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		in_ready = (state_q == ST_IDLE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else         state_q <= state_d;
	end

	// shared multiplier operands
	logic signed [33:0] op_a, op_b;
	logic [16:0]        one_minus;

	assign one_minus = 17'd65536 - {1'b0, alpha_q};

	always_comb begin
		op_a = 34'sd0;
		op_b = 34'sd0;
		case (mstep_q)
			MS_INCR:  begin op_a = 34'(wy_q);   op_b = {10'b0, tstep_q};   end
			MS_GYRO:  begin op_a = fsum_q;      op_b = {18'b0, alpha_q};   end
			MS_ACCEL: begin op_a = 34'(acc_q);  op_b = {17'b0, one_minus}; end
			MS_RATE:  begin
				op_a = 34'(theta_q) - 34'(prev_q);
				op_b = {18'b0, inv_q};
			end
			MS_GA:    begin op_a = 34'(theta_q);  op_b = 34'(g_ang_q);   end
			MS_GR:    begin op_a = 34'(dtheta_q); op_b = 34'(g_rate_q);  end
			MS_GW:    begin op_a = 34'(dphi_q);   op_b = 34'(g_wheel_q); end
			default: ;
		endcase
	end

	// CORDIC step
	logic signed [33:0] sh_x, sh_y, x0, y0;
	logic signed [34:0] tab;
	logic signed [32:0] yd;
	logic signed [67:0] rnd16;
	logic signed [49:0] lim_s;

	assign sh_x  = cx_q >>> cnt_q;
	assign sh_y  = cy_q >>> cnt_q;
	assign tab   = 35'(ATAN_TAB[ATAN_IDX_W'(cnt_q)]);
	assign x0    = 34'(az_q) <<< 14;
	assign y0    = -(34'(ax_q) <<< 14);
	assign yd    = 33'(wz_q) - 33'(wzref_q);
	assign rnd16 = (prod_q + 68'sd32768) >>> 16;
	assign lim_s = signed'(50'(lim_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_FIN2 && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mstep_q     <= MS_INCR;
			cnt_q       <= '0;
			warmup_q    <= 2'd0;
			warm_q      <= 1'b0;
			fp_q        <= 32'sd0;
			prev_q      <= 32'sd0;
		end else begin
			unique case (state_q)
				ST_IDLE: if (accept) begin
					warm_q <= warm_take;
					if (warm_take) begin
						warmup_q <= warmup_q + 2'd1;
						fp_q     <= init_q;
						prev_q   <= init_q;
					end
					ax_q    <= accel_forward;
					az_q    <= accel_vertical;
					wy_q    <= pitch_rate;
					wz_q    <= yaw_rate;
					wl_q    <= wheel_rate_left;
					wr_q    <= wheel_rate_right;
					vref_q  <= forward_speed_ref;
					wzref_q <= yaw_rate_ref;
				end
				ST_PRE: begin
					zero_q <= (ax_q == 16'sd0) && (az_q == 16'sd0);
					cnt_q  <= '0;
					diff_q <= (36'(yd) <<< 2) + 36'(yd);
					if (az_q < 0) begin
						// left half plane: fold by pi
						cx_q <= -x0;
						cy_q <= -y0;
						cz_q <= (y0 >= 0) ? PI_Q30 : -PI_Q30;
					end else begin
						cx_q <= x0;
						cy_q <= y0;
						cz_q <= 35'sd0;
					end
				end
				ST_CORDIC: begin
					if (!cy_q[33]) begin
						cx_q <= cx_q + sh_y;
						cy_q <= cy_q - sh_x;
						cz_q <= cz_q + tab;
					end else begin
						cx_q <= cx_q - sh_y;
						cy_q <= cy_q + sh_x;
						cz_q <= cz_q - tab;
					end
					cnt_q <= cnt_q + CNT_W'(1);
				end
				ST_ATAN: begin
					acc_q   <= zero_q ? 32'sd0 : 32'((cz_q + 35'sd8192) >>> 14);
					mstep_q <= MS_INCR;
				end
				ST_MUL: begin
					prod_q <= op_a * op_b;
					if (mstep_q == MS_GA)
						dphi_q <= sat32(68'(dtheta_q) + ((68'(wl_q) + 68'(wr_q)) >>> 1)
							- 68'(vref_q));
				end
				ST_ACC: begin
					case (mstep_q)
						MS_INCR:  fsum_q <= 34'(fp_q)
							+ 34'((prod_q + 68'sd8388608) >>> 24);
						MS_GYRO:  sum_q <= 52'(prod_q);
						MS_ACCEL: begin
							theta_q <= sat32((68'(sum_q) + prod_q + 68'sd32768) >>> 16);
							fp_q    <= sat32((68'(sum_q) + prod_q + 68'sd32768) >>> 16);
						end
						MS_RATE: begin
							dtheta_q <= sat32(prod_q);
							prev_q   <= theta_q;
						end
						MS_GA:    uacc_q <= 50'(rnd16);
						MS_GR,
						MS_GW:    uacc_q <= uacc_q + 50'(rnd16);
						default: ;
					endcase
					mstep_q <= mstep_t'(mstep_q + 3'd1);
				end
				ST_FIN1: begin
					if (uacc_q > lim_s)
						u_q <= -32'(lim_q);
					else if (uacc_q < -lim_s)
						u_q <= 32'(lim_q);
					else
						u_q <= -32'(uacc_q);
				end
				ST_FIN2: if (out_free) begin
					if (warm_q) begin
						tl_q <= 32'sd0;
						tr_q <= 32'sd0;
					end else begin
						tl_q <= sat32((68'(u_q) + 68'(diff_q)) >>> 1);
						tr_q <= sat32((68'(u_q) - 68'(diff_q)) >>> 1);
					end
				end
				default: ;
			endcase
		end
	end

	assign out_valid    = out_valid_q;
	assign torque_left  = tl_q;
	assign torque_right = tr_q;

`include "balance_robot_pitch_controller_core_assert.svh"

	`BRPC_ASSERT(a_busy_after_take, accept |=> !in_ready, "sequencer idle after item taken")
	`BRPC_ASSERT(a_result_from_fin, $rose(out_valid) |-> $past(state_q == ST_FIN2), "result outside final step")
	`BRPC_NEVER(a_warmup_range, warmup_q == 2'd3, "warm-up count overran")
	`BRPC_ASSERT(a_hold_result, state_q == ST_FIN2 && !out_free |=> $stable(tl_q) && $stable(tr_q), "waiting result overwritten")

endmodule

// File: bench/tb_balance_robot_pitch_controller_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Pitch controller core testbench
// Drives control ticks through valid/ready with random gaps and stalls,
// rewrites the registers between phases and checks each torque pair against
// a cycle-free model of the filter and feedback law.
// ----------------------------------------------------------------------------
module tb_balance_robot_pitch_controller_core;
	import brpc_pkg::*;

	typedef struct {
		logic signed [15:0] ax, az;
		logic signed [31:0] wy, wz, wl, wr, vref, wzref;
	} tick_t;

	typedef struct {
		logic signed [31:0] left, right;
	} torque_t;

	typedef struct {
		tick_t   t;
		bit      known;
		torque_t q;
	} row_t;

	localparam longint PI_ANG = 64'sd3373259426;

	logic clk = 1'b0, arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [2:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;
	logic in_valid = 1'b0, out_ready = 1'b0;
	logic signed [15:0] accel_forward = '0, accel_vertical = '0;
	logic signed [31:0] pitch_rate = '0, yaw_rate = '0, wheel_rate_left = '0;
	logic signed [31:0] wheel_rate_right = '0, forward_speed_ref = '0, yaw_rate_ref = '0;
	logic in_ready, out_valid;
	logic signed [31:0] torque_left, torque_right;

	balance_robot_pitch_controller_core dut (.*);

	initial begin
		forever #1 clk = ~clk;
	end

	// predictor state and register copy
	longint r_alpha, r_dt, r_inv, r_ga, r_gr, r_gw, r_lim, r_init;
	longint pitch_est, pitch_prev;
	int warm;
	torque_t torque_q[$];
	bit failed = 1'b0;
	bit stim_done = 1'b0;

	function automatic longint asr(longint v, int k);
		return v >>> k;
	endfunction

	function automatic longint clip32(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	function automatic longint accel_angle(longint yn, longint xd);
		longint x, y, z, nx;
		x = xd * 16384;
		y = yn * 16384;
		z = 0;
		if (x == 0 && y == 0) return 0;
		if (x < 0) begin
			z = (y >= 0) ? PI_ANG : -PI_ANG;
			x = -x;
			y = -y;
		end
		for (int i = 0; i < 16; i++) begin
			if (y >= 0) begin
				nx = x + asr(y, i);
				y = y - asr(x, i);
				z += longint'(ATAN_TAB[i]);
			end else begin
				nx = x - asr(y, i);
				y = y + asr(x, i);
				z -= longint'(ATAN_TAB[i]);
			end
			x = nx;
		end
		return asr(z + 8192, 14);
	endfunction

	function automatic longint qmul(longint a, longint b);
		return asr(a * b + 32768, 16);
	endfunction

	function automatic torque_t balance_torque(tick_t t);
		torque_t q;
		longint acc, incr, th, dth, dphi, u, diff;
		if (warm < 2) begin
			warm++;
			pitch_est = r_init;
			pitch_prev = r_init;
			q.left = 0;
			q.right = 0;
			return q;
		end
		acc = accel_angle(-longint'(t.ax), longint'(t.az));
		incr = asr(longint'(t.wy) * r_dt + (64'sd1 << 23), 24);
		th = clip32(asr(r_alpha * (pitch_est + incr) + (65536 - r_alpha) * acc + 32768, 16));
		pitch_est = th;
		dth = clip32((th - pitch_prev) * r_inv);
		pitch_prev = th;
		dphi = clip32(dth + asr(longint'(t.wl) + longint'(t.wr), 1) - longint'(t.vref));
		u = qmul(th, r_ga) + qmul(dth, r_gr) + qmul(dphi, r_gw);
		if (u > r_lim) u = r_lim;
		if (u < -r_lim) u = -r_lim;
		u = -u;
		diff = 5 * (longint'(t.wz) - longint'(t.wzref));
		q.left = clip32(asr(u + diff, 1));
		q.right = clip32(asr(u - diff, 1));
		return q;
	endfunction

	// write enable stays up across a burst; the caller drops it afterwards
	task automatic write_reg(logic [2:0] idx, logic [31:0] v);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		case (idx)
			REG_ALPHA:      r_alpha = v[15:0];
			REG_TIME_STEP:  r_dt = v[23:0];
			REG_INV_STEP:   r_inv = v[15:0];
			REG_GAIN_ANGLE: r_ga = longint'(signed'(v));
			REG_GAIN_RATE:  r_gr = longint'(signed'(v));
			REG_GAIN_WHEEL: r_gw = longint'(signed'(v));
			REG_TORQUE_LIM: r_lim = v[30:0];
			REG_INIT_PITCH: r_init = longint'(signed'(v));
			default: ;
		endcase
	endtask

	task automatic send_tick(tick_t t);
		int gap;
		gap = $urandom_range(0, 3);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		accel_forward <= t.ax;
		accel_vertical <= t.az;
		pitch_rate <= t.wy;
		yaw_rate <= t.wz;
		wheel_rate_left <= t.wl;
		wheel_rate_right <= t.wr;
		forward_speed_ref <= t.vref;
		yaw_rate_ref <= t.wzref;
		do @(posedge clk); while (!in_ready);
		torque_q.push_back(balance_torque(t));
	endtask

	function automatic tick_t rand_tick(bit wide);
		tick_t t;
		t.ax = 16'($urandom);
		t.az = 16'($urandom);
		t.wy = $urandom;
		t.wz = $urandom;
		t.wl = $urandom;
		t.wr = $urandom;
		t.vref = $urandom;
		t.wzref = $urandom;
		if (!wide) begin
			// plausible motion: small rates keep the filter off the rails
			t.wy = $signed(t.wy) >>> 14;
			t.wz = $signed(t.wz) >>> 12;
			t.wl = $signed(t.wl) >>> 10;
			t.wr = $signed(t.wr) >>> 10;
			t.vref = $signed(t.vref) >>> 10;
			t.wzref = $signed(t.wzref) >>> 12;
		end
		return t;
	endfunction

	task automatic drain;
		in_valid <= 1'b0;
		while (torque_q.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	// receiver with random stalls; compare on the accepting edge
	initial begin
		torque_t e;
		int gap_n;
		gap_n = 0;
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) begin
				if (torque_q.size() == 0) begin
					$error("torque pair with nothing expected");
					failed = 1'b1;
				end else begin
					e = torque_q.pop_front();
					if (torque_left !== e.left) begin
						$error("torque_left exp %0d got %0d", e.left, torque_left);
						failed = 1'b1;
					end
					if (torque_right !== e.right) begin
						$error("torque_right exp %0d got %0d", e.right, torque_right);
						failed = 1'b1;
					end
				end
				gap_n = $urandom_range(0, 3);
				if (gap_n != 0)
					out_ready <= 1'b0;
			end else if (!out_ready) begin
				if (gap_n > 1)
					gap_n--;
				else
					out_ready <= 1'b1;
			end
		end
	end

	row_t dir[$];

	initial begin
		row_t r;
		tick_t z;
		z = '{default: '0};
		r_alpha = 65463; r_dt = 16777; r_inv = 1000;
		r_ga = -73363000; r_gr = -26059400; r_gw = -926810;
		r_lim = 32768000; r_init = 0;
		pitch_est = 0; pitch_prev = 0; warm = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// warm-up rows give zero; the rest go through the predictor
		r = '{t: z, known: 1'b1, q: '{0, 0}};
		r.t.ax = 16'sh7FFF; dir.push_back(r);
		r.t.ax = 16'sh8000; dir.push_back(r);
		r = '{t: z, known: 1'b0, q: '{0, 0}};
		dir.push_back(r);                              // zero acceleration
		r.t.az = -16'sd100; dir.push_back(r);          // pointing straight down
		r.t.az = 16'sh8000; r.t.ax = 16'sh8000; dir.push_back(r);
		r.t.az = 16'sh7FFF; r.t.ax = 16'sh7FFF; dir.push_back(r);
		r.t.ax = 16'sd0; r.t.az = 16'sd1; dir.push_back(r);
		r.t.wy = 32'sh7FFFFFFF; r.t.wz = 32'sh7FFFFFFF; r.t.wzref = 32'sh80000000;
		r.t.wl = 32'sh7FFFFFFF; r.t.wr = 32'sh7FFFFFFF; r.t.vref = 32'sh80000000;
		dir.push_back(r);
		r.t.wy = 32'sh80000000; r.t.wz = 32'sh80000000; r.t.wzref = 32'sh7FFFFFFF;
		r.t.wl = 32'sh80000000; r.t.wr = 32'sh80000000; r.t.vref = 32'sh7FFFFFFF;
		dir.push_back(r);
		r.t = z; r.t.az = 16'sd16384; r.t.ax = -16'sd3000; dir.push_back(r);

		foreach (dir[i]) begin
			send_tick(dir[i].t);
			if (dir[i].known) begin
				torque_q[$] = dir[i].q;
			end
		end
		drain();

		// register settings, extremes included; random traffic in each
		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
				0: begin
					write_reg(REG_ALPHA, 32'd0);
					write_reg(REG_TIME_STEP, 32'hFFFFFF);
					write_reg(REG_INV_STEP, 32'd65535);
					write_reg(REG_TORQUE_LIM, 32'h7FFFFFFF);
				end
				1: begin
					write_reg(REG_ALPHA, 32'd65535);
					write_reg(REG_TIME_STEP, 32'd1);
					write_reg(REG_INV_STEP, 32'd1);
					write_reg(REG_GAIN_ANGLE, 32'h7FFFFFFF);
					write_reg(REG_GAIN_RATE, 32'h80000000);
					write_reg(REG_GAIN_WHEEL, 32'h7FFFFFFF);
					write_reg(REG_TORQUE_LIM, 32'd0);
				end
				2: begin
					write_reg(REG_GAIN_ANGLE, 32'h80000000);
					write_reg(REG_GAIN_RATE, 32'h7FFFFFFF);
					write_reg(REG_GAIN_WHEEL, 32'h80000000);
					write_reg(REG_TORQUE_LIM, 32'h40000000);
					write_reg(REG_INIT_PITCH, 32'h7FFFFFFF);
				end
				3: begin
					write_reg(REG_INIT_PITCH, 32'h80000000);
					write_reg(REG_TIME_STEP, 32'd0);
					write_reg(REG_INV_STEP, 32'd0);
				end
				default: begin
					write_reg(REG_ALPHA, $urandom);
					write_reg(REG_TIME_STEP, $urandom_range(1, 24'hFFFFFF));
					write_reg(REG_INV_STEP, $urandom_range(1, 65535));
					write_reg(REG_GAIN_ANGLE, $urandom);
					write_reg(REG_GAIN_RATE, $signed($urandom) >>> $urandom_range(0, 8));
					write_reg(REG_GAIN_WHEEL, $signed($urandom) >>> $urandom_range(0, 8));
					write_reg(REG_TORQUE_LIM, $urandom);
					write_reg(REG_INIT_PITCH, $signed($urandom) >>> $urandom_range(0, 12));
				end
			endcase
			cfg_we <= 1'b0;
			for (int n = 0; n < 100; n++) begin
				send_tick(rand_tick($urandom_range(0, 4) == 0));
			end
			drain();
		end
		stim_done = 1'b1;
	end

	initial begin
		wait (stim_done);
		if (!failed && torque_q.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	initial begin
		#400000;
		$display("Regression FAIL");
		$finish;
	end

endmodule
